FILE: sv/sorted_timer_queue_assert.svh
// Assertion macros for the sorted timer queue.
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A condition that holds at every clock edge outside reset.
`define STQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, once seen, implies another in the following cycle.
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define STQ_ASSERT_ALWAYS(lbl, cond, msg)
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: sv/stq_pkg.sv
// Types and constants shared by the sorted timer queue modules.
`default_nettype none

package stq_pkg;

  localparam int DL_W     = 64;
  localparam int HANDLE_W = 16;
  localparam int DELAY_W  = 16;
  localparam int RATE_W   = 32;
  localparam int PROD_W   = DELAY_W + RATE_W;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [DL_W-1:0]   ALL_ONES        = '1;
  localparam logic [RATE_W-1:0] RESET_TICK_RATE = 32'd24000000;

  localparam logic ACT_ADD     = 1'b0;
  localparam logic ACT_SERVICE = 1'b1;

  // Word index of the tick rate register, taken from paddr[2].
  localparam logic REG_TICK_RATE = 1'b0;

  typedef enum logic [1:0] {
    KIND_FIRED   = 2'd0,
    KIND_COMPARE = 2'd1,
    KIND_ADDED   = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_INSERT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic                ins;
    logic                pop;
    logic [DL_W-1:0]     ins_deadline;
    logic [HANDLE_W-1:0] ins_handle;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/stq_cell.sv
// One slot of the sorted chain: holds a deadline and a handle.
`default_nettype none

module stq_cell (
  input  wire logic                         clk,
  input  wire stq_pkg::cell_ctrl_t          ctrl,
  input  wire logic                         occupied,
  input  wire logic                         prev_after,
  input  wire logic [stq_pkg::DL_W-1:0]     prev_deadline,
  input  wire logic [stq_pkg::HANDLE_W-1:0] prev_handle,
  input  wire logic [stq_pkg::DL_W-1:0]     next_deadline,
  input  wire logic [stq_pkg::HANDLE_W-1:0] next_handle,
  output logic                              after,
  output logic [stq_pkg::DL_W-1:0]          deadline,
  output logic [stq_pkg::HANDLE_W-1:0]      handle
);
  import stq_pkg::*;

  // The new timer goes behind every entry that is due no later than it.
  assign after = occupied && (deadline <= ctrl.ins_deadline);

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      deadline <= next_deadline;
      handle   <= next_handle;
    end else if (ctrl.ins && !after) begin
      if (prev_after) begin
        deadline <= ctrl.ins_deadline;
        handle   <= ctrl.ins_handle;
      end else begin
        deadline <= prev_deadline;
        handle   <= prev_handle;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/sorted_timer_queue.sv
// Top level of the sorted timer deadline queue.
//
// Item channel (item_valid/item_stall): action 0 adds a timer with deadline
// now + delay_sec * tick_rate; action 1 services every entry due at now.
// Result channel (result_valid/result_stall): one beat per result, last set
// on the final beat of an item.
// An add passes through a multiply, a 64-bit add, and an insert step in
// which every cell of the chain compares and shifts at once and the result
// beat is loaded. The next item can be accepted once the block is back in
// idle. A service loads one beat per cycle while the receiver does not
// stall, one per fired entry and then the compare beat, since the chain
// shifts by one slot per cycle.
// One item is in flight at a time; item_stall stays high until the last
// result beat has been loaded into the output register.
// Reset empties the queue and sets tick_rate to 24000000; it needs no
// clearing pass. While result_stall is high and result_valid is set, the
// output register holds its beat and the chain waits.
// tick_rate is written through the APB port at byte address 0.
`default_nettype none

`include "sorted_timer_queue_assert.svh"

module sorted_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic                         action,
  input  wire logic [stq_pkg::DL_W-1:0]     now,
  input  wire logic [stq_pkg::DELAY_W-1:0]  delay_sec,
  input  wire logic [stq_pkg::HANDLE_W-1:0] handle,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic [1:0]                        kind,
  output logic [stq_pkg::HANDLE_W-1:0]      fired_handle,
  output logic [stq_pkg::DL_W-1:0]          compare_value,
  output logic                              last,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [stq_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [stq_pkg::DATA_W-1:0]   pwdata,
  output logic [stq_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import stq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t              state, state_next;
  logic [CNT_W-1:0]    count;
  logic [RATE_W-1:0]   tick_rate;
  logic [DL_W-1:0]     now_r;
  logic [DELAY_W-1:0]  delay_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [PROD_W-1:0]   prod;
  logic [DL_W-1:0]     new_deadline;

  cell_ctrl_t          ctrl;
  logic                out_free;
  logic                emit;
  kind_t               emit_kind;
  logic [HANDLE_W-1:0] emit_handle;
  logic [DL_W-1:0]     emit_cmp;
  logic                emit_last;
  logic                count_inc;
  logic                count_dec;
  logic                queue_full;
  logic                head_due;
  logic                head_ordered;
  logic                fire_beat;

  logic [DL_W-1:0]     cell_deadline [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] cell_handle   [QUEUE_DEPTH];
  logic                cell_after    [QUEUE_DEPTH];

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TICK_RATE) ? tick_rate : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= RESET_TICK_RATE;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TICK_RATE) begin
      tick_rate <= pwdata;
    end
  end

  // Chain of cells.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                occ;
    logic                p_after;
    logic [DL_W-1:0]     p_dl;
    logic [HANDLE_W-1:0] p_h;
    logic [DL_W-1:0]     n_dl;
    logic [HANDLE_W-1:0] n_h;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign p_after = 1'b1;
      assign p_dl    = '0;
      assign p_h     = '0;
    end else begin : g_mid
      assign p_after = cell_after[i-1];
      assign p_dl    = cell_deadline[i-1];
      assign p_h     = cell_handle[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_dl = '0;
      assign n_h  = '0;
    end else begin : g_inner
      assign n_dl = cell_deadline[i+1];
      assign n_h  = cell_handle[i+1];
    end

    stq_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .occupied      (occ),
      .prev_after    (p_after),
      .prev_deadline (p_dl),
      .prev_handle   (p_h),
      .next_deadline (n_dl),
      .next_handle   (n_h),
      .after         (cell_after[i]),
      .deadline      (cell_deadline[i]),
      .handle        (cell_handle[i])
    );
  end

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE);
  assign queue_full = (count >= CNT_W'(QUEUE_DEPTH));
  assign head_due   = (count != '0) && (cell_deadline[0] <= now_r);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = (action == ACT_ADD) ? ST_MUL : ST_DRAIN;
        end
      end
      ST_MUL:    state_next = ST_ADD;
      ST_ADD:    state_next = ST_INSERT;
      ST_INSERT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free && !head_due) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    emit              = 1'b0;
    emit_kind         = KIND_FIRED;
    emit_handle       = '0;
    emit_cmp          = '0;
    emit_last         = 1'b0;
    count_inc         = 1'b0;
    count_dec         = 1'b0;
    ctrl.ins          = 1'b0;
    ctrl.pop          = 1'b0;
    ctrl.ins_deadline = new_deadline;
    ctrl.ins_handle   = handle_r;
    case (state)
      ST_INSERT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (queue_full) begin
            emit_kind = KIND_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            count_inc = 1'b1;
            // The first cell not ahead of the new timer is the head: it moves.
            if (!cell_after[0]) begin
              emit_kind = KIND_COMPARE;
              emit_cmp  = new_deadline;
            end else begin
              emit_kind = KIND_ADDED;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (head_due) begin
            emit_kind   = KIND_FIRED;
            emit_handle = cell_handle[0];
            ctrl.pop    = 1'b1;
            count_dec   = 1'b1;
          end else begin
            emit_kind = KIND_COMPARE;
            emit_cmp  = (count != '0) ? cell_deadline[0] : ALL_ONES;
            emit_last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (count_inc) begin
        count <= count + CNT_W'(1);
      end else if (count_dec) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Item capture and deadline arithmetic.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      now_r    <= now;
      delay_r  <= delay_sec;
      handle_r <= handle;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(delay_r) * PROD_W'(tick_rate);
    end
    if (state == ST_ADD) begin
      new_deadline <= now_r + DL_W'(prod);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind          <= emit_kind;
      fired_handle  <= emit_handle;
      compare_value <= emit_cmp;
      last          <= emit_last;
    end
  end

  assign head_ordered = (count < CNT_W'(2)) || (cell_deadline[0] <= cell_deadline[1]);
  assign fire_beat    = emit && (emit_kind == KIND_FIRED);

  `STQ_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `STQ_ASSERT_ALWAYS(a_head_order, head_ordered, "head out of order")
  `STQ_ASSERT_NEXT(a_fire_pops, fire_beat, count == $past(count) - CNT_W'(1), "fired beat without pop")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the sorted timer deadline queue.
module tb_top;
  import stq_pkg::*;

  localparam int DEPTH = 16;

  typedef struct packed {
    kind_t               kind;
    logic [HANDLE_W-1:0] handle;
    logic [DL_W-1:0]     cmp;
    logic                last;
  } beat_t;

  typedef struct packed {
    logic [DL_W-1:0]     deadline;
    logic [HANDLE_W-1:0] handle;
  } timer_t;

  // Mirrors the sorted queue and the tick rate, and holds the beats still owed.
  class timer_scoreboard;
    int                depth;
    int                errors;
    logic [RATE_W-1:0] tick_rate;
    timer_t            timers[$];
    beat_t             owed_beats[$];

    function new(int d);
      depth     = d;
      errors    = 0;
      tick_rate = RESET_TICK_RATE;
    endfunction

    function void owe(kind_t k, logic [HANDLE_W-1:0] h, logic [DL_W-1:0] c, logic l);
      beat_t b;
      b.kind   = k;
      b.handle = h;
      b.cmp    = c;
      b.last   = l;
      owed_beats.push_back(b);
    endfunction

    function void note_item(logic act, logic [DL_W-1:0] t, logic [DELAY_W-1:0] d,
                            logic [HANDLE_W-1:0] h);
      logic [DL_W-1:0] dl;
      int              pos;
      timer_t          tm;
      if (act == ACT_ADD) begin
        dl = t + 64'(d) * 64'(tick_rate);
        if (timers.size() >= depth) begin
          owe(KIND_FULL, '0, '0, 1'b1);
        end else begin
          // Equal deadlines keep their arrival order.
          pos = 0;
          while (pos < timers.size() && timers[pos].deadline <= dl) pos++;
          tm.deadline = dl;
          tm.handle   = h;
          timers.insert(pos, tm);
          if (pos == 0) owe(KIND_COMPARE, '0, dl, 1'b1);
          else owe(KIND_ADDED, '0, '0, 1'b1);
        end
      end else begin
        while (timers.size() > 0 && timers[0].deadline <= t) begin
          owe(KIND_FIRED, timers[0].handle, '0, 1'b0);
          void'(timers.pop_front());
        end
        owe(KIND_COMPARE, '0, (timers.size() > 0) ? timers[0].deadline : ALL_ONES, 1'b1);
      end
    endfunction

    function void check_result(logic [1:0] k, logic [HANDLE_W-1:0] h, logic [DL_W-1:0] c,
                               logic l);
      beat_t e;
      if (owed_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d handle %h compare %h", k, h, c);
        errors++;
        return;
      end
      e = owed_beats.pop_front();
      if (k !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, k);
        errors++;
      end
      if (h !== e.handle) begin
        $error("fired_handle: expected %h, got %h", e.handle, h);
        errors++;
      end
      if (c !== e.cmp) begin
        $error("compare_value: expected %h, got %h", e.cmp, c);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, l);
        errors++;
      end
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic                action = ACT_ADD;
  logic [DL_W-1:0]     now = '0;
  logic [DELAY_W-1:0]  delay_sec = '0;
  logic [HANDLE_W-1:0] handle = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [1:0]          kind;
  logic [HANDLE_W-1:0] fired_handle;
  logic [DL_W-1:0]     compare_value;
  logic                last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  timer_scoreboard sb;
  bit              idle_on = 1'b1;
  int              stall_run = 0;
  logic [DL_W-1:0] tnow;

  sorted_timer_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiving side: checks each accepted beat and stalls in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_run    <= 0;
    end else begin
      if (result_valid && !result_stall)
        sb.check_result(kind, fired_handle, compare_value, last);
      if (stall_run != 0) begin
        stall_run <= stall_run - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        stall_run    <= $urandom_range(0, 18);
      end else begin
        result_stall <= 1'b0;
        stall_run    <= $urandom_range(0, 12);
      end
    end
  end

  task automatic send_item(logic act, logic [DL_W-1:0] t, logic [DELAY_W-1:0] d,
                           logic [HANDLE_W-1:0] h);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    now        <= t;
    delay_sec  <= d;
    handle     <= h;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(act, t, d, h);
  endtask

  task automatic wait_for_drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the tick rate, read it back, and update the mirror.
  task automatic write_rate(logic [RATE_W-1:0] val);
    logic [DATA_W-1:0] rb;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TICK_RATE, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rb = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rb !== val) begin
      $error("tick_rate: expected %h, got %h", val, rb);
      sb.errors++;
    end
    sb.tick_rate = val;
  endtask

  // Mostly well-ordered adds and services on an advancing timebase, with noise.
  task automatic random_items(int n);
    int                sel;
    logic [DELAY_W-1:0] d;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        send_item(1'($urandom_range(0, 1)), {$urandom, $urandom}, 16'($urandom),
                  16'($urandom));
      end else if (sel < 60) begin
        d = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        send_item(ACT_ADD, tnow, d, 16'($urandom));
      end else if (sel < 63) begin
        send_item(ACT_SERVICE, ALL_ONES, 16'($urandom), 16'($urandom));
      end else begin
        tnow = tnow + 64'($urandom_range(0, 3)) * 64'(sb.tick_rate)
               + 64'($urandom_range(0, 2));
        send_item(ACT_SERVICE, tnow, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    logic [RATE_W-1:0] rates[5];
    sb = new(DEPTH);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset tick rate.
    send_item(ACT_SERVICE, 64'd0, 16'd0, 16'd0);
    send_item(ACT_ADD, 64'd0, 16'd0, 16'h0000);
    send_item(ACT_ADD, 64'd0, 16'd0, 16'hFFFF);
    // The deadline wraps past the top of the 64-bit range.
    send_item(ACT_ADD, ALL_ONES, 16'hFFFF, 16'h1234);
    send_item(ACT_ADD, ALL_ONES, 16'd0, 16'h5678);
    for (int i = 0; i < DEPTH - 4; i++)
      send_item(ACT_ADD, 64'(i) * 64'd1000, 16'(i % 3), 16'(16'h0100 + i));
    send_item(ACT_ADD, 64'd0, 16'd0, 16'hAAAA);
    send_item(ACT_ADD, ALL_ONES, 16'hFFFF, 16'hFFFF);
    send_item(ACT_SERVICE, ALL_ONES, 16'd0, 16'd0);
    send_item(ACT_ADD, 64'd5, 16'd1, 16'h00FF);
    send_item(ACT_SERVICE, 64'd24000004, 16'hFFFF, 16'hFFFF);
    send_item(ACT_SERVICE, 64'd24000005, 16'd0, 16'd0);
    wait_for_drain();

    rates[0] = 32'd1;
    rates[1] = 32'hFFFF_FFFF;
    rates[2] = 32'($urandom_range(2, 5000));
    rates[3] = $urandom;
    rates[4] = RESET_TICK_RATE;
    for (int p = 0; p < 5; p++) begin
      write_rate(rates[p]);
      tnow = {$urandom, $urandom} >> 2;
      if (p == 4) idle_on = 1'b0;
      random_items(50);
      wait_for_drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+sv
sv/stq_pkg.sv
sv/stq_cell.sv
sv/sorted_timer_queue.sv
tb/tb_top.sv
